>>> sv/assembly_line_lexer_defines.svh
// assertion macros shared by the lexer checkers
// no dependencies; included by the checker file
`ifndef ASSEMBLY_LINE_LEXER_DEFINES_SVH
`define ASSEMBLY_LINE_LEXER_DEFINES_SVH

// clocked property, masked while reset is high
`define LAL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lexer assertion failed");

// clocked property, checked through reset as well
`define LAL_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("lexer assertion failed");

`endif

>>> sv/lal_pkg.sv
// types, token codes and the keyword table for the assembly line lexer
// no dependencies; used by the scan core, the queue, the top level and the checker
package lal_pkg;

   // token type codes
   localparam logic [3:0] TOK_BAD      = 4'd0;
   localparam logic [3:0] TOK_MNEMONIC = 4'd1;
   localparam logic [3:0] TOK_SIZE     = 4'd2;
   localparam logic [3:0] TOK_REGISTER = 4'd3;
   localparam logic [3:0] TOK_NUMBER   = 4'd4;
   localparam logic [3:0] TOK_PLUS     = 4'd5;
   localparam logic [3:0] TOK_MINUS    = 4'd6;
   localparam logic [3:0] TOK_OPEN     = 4'd7;
   localparam logic [3:0] TOK_CLOSE    = 4'd8;
   localparam logic [3:0] TOK_COMMA    = 4'd9;
   localparam logic [3:0] TOK_END      = 4'd10;

   // keyword table
   localparam int          NUM_KEYWORDS = 22;
   localparam logic [4:0]  NO_KEYWORD   = 5'd22;
   localparam logic [31:0] KEYWORD_TEXT [NUM_KEYWORDS] = '{
      32'h006d6f76, 32'h00616464, 32'h00737562, 32'h00636d70,  // mov add sub cmp
      32'h62797465, 32'h776f7264,                              // byte word
      32'h0000616c, 32'h00006168, 32'h00006178,                // al ah ax
      32'h0000636c, 32'h00006368, 32'h00006378,                // cl ch cx
      32'h0000646c, 32'h00006468, 32'h00006478,                // dl dh dx
      32'h0000626c, 32'h00006268, 32'h00006278,                // bl bh bx
      32'h00007370, 32'h00006270, 32'h00007369, 32'h00006469   // sp bp si di
   };

   // character codes with a meaning of their own
   localparam logic [7:0] CHAR_END       = 8'd0;
   localparam logic [7:0] CHAR_SEMICOLON = 8'h3b;
   localparam logic [7:0] CHAR_PLUS      = 8'h2b;
   localparam logic [7:0] CHAR_MINUS     = 8'h2d;
   localparam logic [7:0] CHAR_OPEN      = 8'h5b;
   localparam logic [7:0] CHAR_CLOSE     = 8'h5d;
   localparam logic [7:0] CHAR_COMMA     = 8'h2c;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // one result word
   typedef struct packed {
      logic [3:0]  token_type;
      logic [4:0]  keyword_index;
      logic [7:0]  start_column;
      logic [7:0]  token_length;
      logic [15:0] token_line;
      logic        last;
   } token_word_type;

   // up to two result words produced by one character
   typedef struct packed {
      logic [1:0]     count;
      token_word_type first;
      token_word_type second;
   } push_type;

   // token type of a keyword table entry
   function automatic logic [3:0] keyword_class(input logic [4:0] idx);
      logic [3:0] cls;
      if (idx < 5'd4) begin
         cls = TOK_MNEMONIC;
      end else if (idx < 5'd6) begin
         cls = TOK_SIZE;
      end else if (idx < NO_KEYWORD) begin
         cls = TOK_REGISTER;
      end else begin
         cls = TOK_BAD;
      end
      return cls;
   endfunction

endpackage

>>> sv/lal_if.sv
// valid/ready channel interfaces for characters and tokens
// depends on nothing but plain logic types
interface lal_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  char_byte;
   logic [15:0] line_number;

   modport source (output valid, output char_byte, output line_number, input ready);
   modport sink   (input valid, input char_byte, input line_number, output ready);
endinterface

interface lal_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_type;
   logic [4:0]  keyword_index;
   logic [7:0]  start_column;
   logic [7:0]  token_length;
   logic [15:0] token_line;
   logic        last;

   modport source (output valid, output token_type, output keyword_index,
                   output start_column, output token_length, output token_line,
                   output last, input ready);
   modport sink   (input valid, input token_type, input keyword_index,
                   input start_column, input token_length, input token_line,
                   input last, output ready);
endinterface

>>> sv/lal_scan_core.sv
// scanner state and per-character token logic of the lexer
// depends on lal_pkg for codes, the keyword table and the token structs
module lal_scan_core #(
   parameter int MAX_COLUMN    = 255,
   parameter int KEYWORD_CHARS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          char_byte,
   input  logic [15:0]         line_number,
   output lal_pkg::push_type   push
);

   localparam int COL_W = $clog2(MAX_COLUMN + 1);
   localparam int BUF_W = 8 * KEYWORD_CHARS;

   // scan mode codes
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_NUM     = 2'd1;
   localparam logic [1:0] MODE_WORD    = 2'd2;
   localparam logic [1:0] MODE_COMMENT = 2'd3;

   logic [1:0]       mode_ff, mode_in;
   logic [COL_W-1:0] column_ff, column_in;
   logic [COL_W-1:0] run_start_ff, run_start_in;
   logic [7:0]       run_length_ff, run_length_in;
   logic [BUF_W-1:0] word_ff, word_in;
   logic             too_long_ff, too_long_in;

   logic is_digit, is_upper, is_lower, is_letter, is_space, is_punct;
   logic [7:0] lower_char;
   logic [3:0] punct_type;
   logic [COL_W-1:0] column_next;
   logic [7:0] run_length_inc;
   logic [7:0] column_clamp, run_start_clamp;
   logic [4:0] kw_idx;
   logic pend_valid, proceed, tok_valid;
   lal_pkg::token_word_type pend_tok, tok;

   // character classes
   assign is_digit   = (char_byte >= 8'd48) && (char_byte <= 8'd57);
   assign is_upper   = (char_byte >= 8'd65) && (char_byte <= 8'd90);
   assign is_lower   = (char_byte >= 8'd97) && (char_byte <= 8'd122);
   assign is_letter  = is_upper || is_lower;
   assign is_space   = (char_byte == 8'd32) || ((char_byte >= 8'd9) && (char_byte <= 8'd13));
   assign lower_char = is_upper ? (char_byte + 8'd32) : char_byte;
   assign is_punct   = (char_byte == lal_pkg::CHAR_PLUS) || (char_byte == lal_pkg::CHAR_MINUS)
                    || (char_byte == lal_pkg::CHAR_OPEN) || (char_byte == lal_pkg::CHAR_CLOSE)
                    || (char_byte == lal_pkg::CHAR_COMMA);

   always_comb begin
      case (char_byte)
         lal_pkg::CHAR_PLUS:  punct_type = lal_pkg::TOK_PLUS;
         lal_pkg::CHAR_MINUS: punct_type = lal_pkg::TOK_MINUS;
         lal_pkg::CHAR_OPEN:  punct_type = lal_pkg::TOK_OPEN;
         lal_pkg::CHAR_CLOSE: punct_type = lal_pkg::TOK_CLOSE;
         default:             punct_type = lal_pkg::TOK_COMMA;
      endcase
   end

   // saturating column and run counters
   assign column_next     = (32'(column_ff) < MAX_COLUMN) ? (column_ff + 1'b1) : column_ff;
   assign run_length_inc  = (run_length_ff == 8'd255) ? run_length_ff : (run_length_ff + 8'd1);
   assign column_clamp    = (32'(column_ff) > 32'd255) ? 8'd255 : 8'(column_ff);
   assign run_start_clamp = (32'(run_start_ff) > 32'd255) ? 8'd255 : 8'(run_start_ff);

   // parallel keyword compare, lowest entry wins
   always_comb begin
      kw_idx = lal_pkg::NO_KEYWORD;
      for (int i = lal_pkg::NUM_KEYWORDS - 1; i >= 0; i--) begin
         if (!too_long_ff && (word_ff == BUF_W'(lal_pkg::KEYWORD_TEXT[i]))) begin
            kw_idx = 5'(i);
         end
      end
   end

   // pending number or word closed by this character
   always_comb begin
      pend_valid             = 1'b0;
      pend_tok.token_type    = lal_pkg::TOK_NUMBER;
      pend_tok.keyword_index = lal_pkg::NO_KEYWORD;
      pend_tok.start_column  = run_start_clamp;
      pend_tok.token_length  = run_length_ff;
      pend_tok.token_line    = line_number;
      pend_tok.last          = 1'b0;
      if ((mode_ff == MODE_NUM) && !is_digit) begin
         pend_valid = 1'b1;
      end else if ((mode_ff == MODE_WORD) && !is_letter) begin
         pend_valid             = 1'b1;
         pend_tok.token_type    = lal_pkg::keyword_class(kw_idx);
         pend_tok.keyword_index = kw_idx;
      end
   end

   // character handled as the start of something new
   assign proceed = (mode_ff == MODE_IDLE) || pend_valid;

   // token of the character itself: end, punctuation or bad
   always_comb begin
      tok_valid         = 1'b0;
      tok.token_type    = lal_pkg::TOK_BAD;
      tok.keyword_index = lal_pkg::NO_KEYWORD;
      tok.start_column  = column_clamp;
      tok.token_length  = 8'd1;
      tok.token_line    = line_number;
      tok.last          = 1'b0;
      if (char_byte == lal_pkg::CHAR_END) begin
         if (proceed || (mode_ff == MODE_COMMENT)) begin
            tok_valid        = 1'b1;
            tok.token_type   = lal_pkg::TOK_END;
            tok.token_length = 8'd0;
            tok.last         = 1'b1;
         end
      end else if (proceed && is_punct) begin
         tok_valid      = 1'b1;
         tok.token_type = punct_type;
      end else if (proceed && !is_space && !is_digit && !is_letter
                   && (char_byte != lal_pkg::CHAR_SEMICOLON)) begin
         tok_valid = 1'b1;
      end
   end

   // pack results in order
   always_comb begin
      push.count  = {1'b0, pend_valid} + {1'b0, tok_valid};
      push.first  = pend_valid ? pend_tok : tok;
      push.second = tok;
   end

   // next scanner state
   always_comb begin
      mode_in       = mode_ff;
      column_in     = column_next;
      run_start_in  = run_start_ff;
      run_length_in = run_length_ff;
      word_in       = word_ff;
      too_long_in   = too_long_ff;
      if (char_byte == lal_pkg::CHAR_END) begin
         mode_in       = MODE_IDLE;
         column_in     = '0;
         run_start_in  = '0;
         run_length_in = '0;
         word_in       = '0;
         too_long_in   = 1'b0;
      end else if ((mode_ff == MODE_NUM) && is_digit) begin
         run_length_in = run_length_inc;
      end else if ((mode_ff == MODE_WORD) && is_letter) begin
         if (32'(run_length_ff) < KEYWORD_CHARS) begin
            word_in = {word_ff[BUF_W-9:0], lower_char};
         end else begin
            too_long_in = 1'b1;
         end
         run_length_in = run_length_inc;
      end else if (mode_ff == MODE_COMMENT) begin
         mode_in = MODE_COMMENT;
      end else begin
         mode_in = MODE_IDLE;
         if (char_byte == lal_pkg::CHAR_SEMICOLON) begin
            mode_in = MODE_COMMENT;
         end else if (is_digit) begin
            mode_in       = MODE_NUM;
            run_start_in  = column_ff;
            run_length_in = 8'd1;
         end else if (is_letter) begin
            mode_in       = MODE_WORD;
            run_start_in  = column_ff;
            run_length_in = 8'd1;
            word_in       = BUF_W'(lower_char);
            too_long_in   = 1'b0;
         end
      end
   end

   // scanner state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         column_ff     <= '0;
         run_start_ff  <= '0;
         run_length_ff <= '0;
         word_ff       <= '0;
         too_long_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         column_ff     <= column_in;
         run_start_ff  <= run_start_in;
         run_length_ff <= run_length_in;
         word_ff       <= word_in;
         too_long_ff   <= too_long_in;
      end
   end

endmodule

>>> sv/lal_token_queue.sv
// small result queue: takes up to two words a cycle, gives one
// depends on lal_pkg for the token structs and queue size
module lal_token_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  lal_pkg::push_type       push,
   input  logic                    pop,
   output lal_pkg::token_word_type head,
   output logic                    not_empty,
   output logic                    has_room
);

   localparam int CNT_W = lal_pkg::QUEUE_AW + 1;

   lal_pkg::token_word_type entry_ff [lal_pkg::QUEUE_DEPTH];
   logic [lal_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lal_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [lal_pkg::QUEUE_AW-1:0] wr_ptr_second;

   assign head          = entry_ff[rd_ptr_ff];
   assign not_empty     = (count_ff != '0);
   assign has_room      = (32'(count_ff) <= lal_pkg::QUEUE_DEPTH - 2);
   assign wr_ptr_second = wr_ptr_ff + 1'b1;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + lal_pkg::QUEUE_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + lal_pkg::QUEUE_AW'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_second] <= push.second;
      end
   end

endmodule

>>> sv/assembly_line_lexer.sv
// assembly line lexer: one character word in, token words out in order
// a token word is registered into the result queue when its character is accepted and is offered from the queue head
// throughput: one character per cycle while the four-entry result queue has two free slots;
//    a character that closes a number or word and is itself a token gives two words
// reset: synchronous, clears scan mode, column and run state and empties the queue
module assembly_line_lexer #(
   parameter int MAX_COLUMN    = 255,
   parameter int KEYWORD_CHARS = 4
) (
   input logic       clock,
   input logic       reset,
   lal_req_if.sink   req_port,
   lal_rsp_if.source rsp_port
);

   logic                    req_accept;
   logic                    rsp_pop;
   logic                    queue_room;
   logic                    queue_valid;
   lal_pkg::push_type       scan_push;
   lal_pkg::push_type       queue_push;
   lal_pkg::token_word_type queue_head;

   // handshakes
   assign req_port.ready = queue_room;
   assign req_accept     = req_port.valid && queue_room;
   assign rsp_pop        = queue_valid && rsp_port.ready;

   lal_scan_core #(
      .MAX_COLUMN    (MAX_COLUMN),
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .char_byte   (req_port.char_byte),
      .line_number (req_port.line_number),
      .push        (scan_push)
   );

   // only accepted characters push words
   always_comb begin
      queue_push       = scan_push;
      queue_push.count = req_accept ? scan_push.count : 2'd0;
   end

   lal_token_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .pop       (rsp_pop),
      .head      (queue_head),
      .not_empty (queue_valid),
      .has_room  (queue_room)
   );

   // result channel
   assign rsp_port.valid         = queue_valid;
   assign rsp_port.token_type    = queue_head.token_type;
   assign rsp_port.keyword_index = queue_head.keyword_index;
   assign rsp_port.start_column  = queue_head.start_column;
   assign rsp_port.token_length  = queue_head.token_length;
   assign rsp_port.token_line    = queue_head.token_line;
   assign rsp_port.last          = queue_head.last;

endmodule

>>> sv/lal_checker.sv
// port-level checks for the assembly line lexer, bound to the top level
// depends on lal_pkg and assembly_line_lexer_defines.svh
`include "assembly_line_lexer_defines.svh"

module lal_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_token_type,
   input logic [4:0] rsp_keyword_index,
   input logic [7:0] rsp_token_length,
   input logic       rsp_last
);

   // a stalled result word stays offered
   `LAL_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // last marks exactly the end token
   `LAL_ASSERT(a_last_is_end, clock, reset, rsp_valid |-> (rsp_last == (rsp_token_type == lal_pkg::TOK_END)))

   // end token has no length and no keyword
   `LAL_ASSERT(a_end_shape, clock, reset, rsp_valid && rsp_last |-> (rsp_token_length == 8'd0) && (rsp_keyword_index == lal_pkg::NO_KEYWORD))

   // keyword index present exactly on keyword tokens
   `LAL_ASSERT(a_keyword_match, clock, reset, rsp_valid |-> ((rsp_keyword_index != lal_pkg::NO_KEYWORD) == ((rsp_token_type == lal_pkg::TOK_MNEMONIC) || (rsp_token_type == lal_pkg::TOK_SIZE) || (rsp_token_type == lal_pkg::TOK_REGISTER))))

   // queue comes out of reset empty
   `LAL_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> !rsp_valid)

endmodule

bind assembly_line_lexer lal_checker u_lal_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_port.valid),
   .rsp_ready         (rsp_port.ready),
   .rsp_token_type    (rsp_port.token_type),
   .rsp_keyword_index (rsp_port.keyword_index),
   .rsp_token_length  (rsp_port.token_length),
   .rsp_last          (rsp_port.last)
);
